[src/gwm_pkg.sv]
// Package for the glob wildcard matcher: opcodes, pattern token bytes,
// controller/datapath command and status types. No dependencies.
`default_nettype none

package gwm_pkg;

  localparam int unsigned PatternLenDef = 32;
  localparam int unsigned PosW          = 5;
  localparam int unsigned ByteW         = 8;

  // Request opcodes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_SUBJECT = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  // Pattern token bytes
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_QMARK = 8'h3F;  // '?'
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRK  = 8'h5D;  // ']'

  typedef struct packed {
    logic wr_en;    // store a pattern byte
    logic start;    // latch subject byte and opcode, clear scan state
    logic advance;  // step the store read pointer and the byte window
    logic scan;     // evaluate the current pattern position
  } gwm_cmd_t;

  typedef struct packed {
    logic at_end;   // current position is the pattern end
    logic is_end;   // request in flight is an end of subject
    logic matched;  // registered match result
  } gwm_stat_t;

endpackage

`default_nettype wire

[src/gwm_datapath.sv]
// Datapath: pattern store with its read port, active-position vectors and
// the per-position token evaluator. Depends on gwm_pkg.
`default_nettype none

module gwm_datapath #(
  parameter int unsigned PATTERN_LEN = gwm_pkg::PatternLenDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gwm_pkg::gwm_cmd_t          cmd_i,
  input  wire logic [gwm_pkg::PosW-1:0]   pos_i,
  input  wire logic [gwm_pkg::ByteW-1:0]  byte_i,
  input  wire logic [1:0]                 opcode_i,
  output gwm_pkg::gwm_stat_t              stat_o
);
  import gwm_pkg::*;

  localparam int unsigned AddrW = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam int unsigned IdxW  = $clog2(PATTERN_LEN + 1);

  typedef enum logic [1:0] {
    PH_OPEN = 2'd0,
    PH_BANG = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  logic [7:0]             mem_q [PATTERN_LEN];
  logic [PATTERN_LEN-1:0] valid_q;
  logic [7:0]             rdata_q;
  logic                   rvalid_q;
  logic [AddrW-1:0]       rptr_q;

  logic [PATTERN_LEN:0]   act_q, nxt_q, nxt_d;
  logic [IdxW-1:0]        q_q, qn;
  logic [7:0]             cur_q, prev_q, subj_q;
  logic                   is_end_q, carry_q, carry_d;
  logic                   in_set_q, in_set_d, set_act_q, set_act_d;
  logic                   neg_q, neg_d, hit_q, hit_d;
  phase_e                 phase_q, phase_d;
  logic                   matched_q;

  logic [7:0] look;
  logic       look_end, at_end, a, ok, wr_ok;

  assign wr_ok = (32'(pos_i) < PATTERN_LEN);
  assign look  = rvalid_q ? rdata_q : 8'h00;
  assign qn    = q_q + 1'b1;
  assign look_end = (({1'b0, q_q} + 1'b1) == (IdxW+1)'(PATTERN_LEN)) || (look == 8'h00);
  assign at_end   = (q_q == IdxW'(PATTERN_LEN)) || (cur_q == 8'h00);
  assign a        = act_q[q_q] | carry_q;

  always_comb begin
    nxt_d     = nxt_q;
    carry_d   = 1'b0;
    in_set_d  = in_set_q;
    set_act_d = set_act_q;
    neg_d     = neg_q;
    hit_d     = hit_q;
    phase_d   = phase_q;
    ok        = 1'b0;
    if (at_end) begin
      // unterminated set closes at the pattern end
      if (in_set_q && set_act_q && (neg_q ^ hit_q)) nxt_d[q_q] = 1'b1;
    end else if (in_set_q) begin
      priority if (phase_q == PH_OPEN && cur_q == CH_BANG) begin
        neg_d   = 1'b1;
        phase_d = PH_BANG;
      end else if (phase_q != PH_BODY && cur_q == CH_DASH) begin
        hit_d   = hit_q | (subj_q == CH_DASH);
        phase_d = PH_BODY;
      end else if (cur_q == CH_RBRK) begin
        in_set_d = 1'b0;
        if (set_act_q && (neg_q ^ hit_q)) nxt_d[qn] = 1'b1;
      end else if (cur_q == CH_DASH && (look_end || look == CH_RBRK)) begin
        hit_d   = hit_q | (subj_q == CH_DASH);
        phase_d = PH_BODY;
      end else if (cur_q == CH_DASH) begin
        // range bounds count through their own literal entries
        hit_d   = hit_q | ((subj_q > prev_q) && (subj_q < look));
        phase_d = PH_BODY;
      end else begin
        hit_d   = hit_q | (subj_q == cur_q);
        phase_d = PH_BODY;
      end
    end else if (cur_q == CH_STAR) begin
      carry_d = a;
      if (a) nxt_d[q_q] = 1'b1;
      if (a || nxt_q[q_q]) nxt_d[qn] = 1'b1;
    end else if (cur_q == CH_LBRK) begin
      in_set_d  = 1'b1;
      set_act_d = a;
      neg_d     = 1'b0;
      hit_d     = 1'b0;
      phase_d   = PH_OPEN;
    end else begin
      priority if (cur_q == CH_QMARK) ok = 1'b1;
      else if (cur_q == CH_HASH) ok = (subj_q >= CH_ZERO) && (subj_q <= CH_NINE);
      else ok = (subj_q == cur_q);
      if (a && ok) nxt_d[qn] = 1'b1;
    end
  end

  // Pattern store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) mem_q[AddrW'(pos_i)] <= byte_i;
    rdata_q <= mem_q[rptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      act_q    <= (PATTERN_LEN+1)'(1);
      rptr_q   <= '0;
      q_q      <= '0;
      carry_q  <= 1'b0;
      in_set_q <= 1'b0;
      is_end_q <= 1'b0;
      phase_q  <= PH_OPEN;
    end else begin
      rvalid_q <= valid_q[rptr_q];
      if (cmd_i.wr_en && wr_ok) begin
        valid_q[AddrW'(pos_i)] <= 1'b1;
        act_q <= (PATTERN_LEN+1)'(1);
      end
      if (cmd_i.start) begin
        rptr_q   <= '0;
        q_q      <= '0;
        carry_q  <= 1'b0;
        in_set_q <= 1'b0;
        phase_q  <= PH_OPEN;
        is_end_q <= (opcode_i == OP_END);
      end
      if (cmd_i.advance) rptr_q <= rptr_q + 1'b1;
      if (cmd_i.scan) begin
        if (!at_end) begin
          q_q      <= qn;
          carry_q  <= carry_d;
          in_set_q <= in_set_d;
          phase_q  <= phase_d;
        end else if (is_end_q) begin
          act_q <= (PATTERN_LEN+1)'(1);
        end else begin
          act_q <= nxt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      subj_q <= byte_i;
      nxt_q  <= '0;
    end
    if (cmd_i.advance) begin
      cur_q  <= look;
      prev_q <= cur_q;
    end
    if (cmd_i.scan && !at_end) begin
      nxt_q     <= nxt_d;
      set_act_q <= set_act_d;
      neg_q     <= neg_d;
      hit_q     <= hit_d;
    end
    if (cmd_i.scan && at_end && is_end_q) matched_q <= a;
  end

  assign stat_o.at_end  = at_end;
  assign stat_o.is_end  = is_end_q;
  assign stat_o.matched = matched_q;

endmodule

`default_nettype wire

[src/gwm_ctrl.sv]
// Controller state machine: request handshake and scan sequencing.
// Depends on gwm_pkg.
`default_nettype none

module gwm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic               out_free_i,
  input  wire gwm_pkg::gwm_stat_t stat_i,
  output logic                    req_ready_o,
  output logic                    out_load_o,
  output gwm_pkg::gwm_cmd_t       cmd_o
);
  import gwm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PRIME0 = 5'b00010,
    ST_PRIME1 = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign req_ready_o = (state_q == ST_IDLE);
  assign acc         = req_valid_i && req_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_load_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (opcode_i == OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else if (opcode_i == OP_SUBJECT || opcode_i == OP_END) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PRIME0;
          end
        end
      end
      ST_PRIME0: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_PRIME1;
      end
      ST_PRIME1: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.advance = 1'b1;
        cmd_o.scan    = 1'b1;
        if (stat_i.at_end) state_d = stat_i.is_end ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

[src/glob_wildcard_matcher.sv]
// Top level of the glob wildcard matcher: stream ports, result register,
// controller and datapath. Depends on gwm_pkg, gwm_ctrl, gwm_datapath.
//
// Write a glob pattern byte by byte (opcode 0, ends at the first zero byte
// or at the store end), stream subject bytes (opcode 1), then send an end
// request (opcode 2) to get one result whose bit 0 says whether the whole
// subject matched; the end request re-arms the matcher for the next subject.
// Patterns support '*', '?', '#' (decimal digit) and '[...]' sets with '!'
// negation and a-z ranges; matching is full glob with backtracking, kept as
// a set of live pattern positions. For each subject byte the matcher
// accepts the request, primes the read pipeline, then the evaluator walks
// the pattern store one entry per cycle through its single read port: the
// L entries of the pattern up to its terminating zero (at most PATTERN_LEN)
// plus the end position. An end request then loads the result register,
// and waits in that step while the previous result is not taken. The store
// needs no clearing pass after reset: per-entry valid bits make unwritten
// entries read zero. Opcode 3 and writes beyond the store are dropped.
`default_nettype none

module glob_wildcard_matcher #(
  parameter int unsigned PATTERN_LEN = gwm_pkg::PatternLenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] opcode, [6:2] pattern_position, [14:7] byte_value, [15] zero
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] matched, [7:1] zero
  output logic [7:0]       m_axis_tdata
);
  import gwm_pkg::*;

  gwm_cmd_t  cmd;
  gwm_stat_t stat;
  logic      out_load, out_free;
  logic      m_valid_q, matched_q;

  // Result slot frees when empty or being taken this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  gwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .opcode_i    (s_axis_tdata[1:0]),
    .out_free_i  (out_free),
    .stat_i      (stat),
    .req_ready_o (s_axis_tready),
    .out_load_o  (out_load),
    .cmd_o       (cmd)
  );

  gwm_datapath #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .pos_i    (s_axis_tdata[6:2]),
    .byte_i   (s_axis_tdata[14:7]),
    .opcode_i (s_axis_tdata[1:0]),
    .stat_o   (stat)
  );

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) matched_q <= stat.matched;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, matched_q};

endmodule

`default_nettype wire
